// ----- hw/rtl/casc_pkg.sv -----
// types and constants shared by the alarm clock set-mode controller
package casc_pkg;

  // command codes
  localparam logic [2:0] CMD_MODE = 3'd0;
  localparam logic [2:0] CMD_SET  = 3'd1;
  localparam logic [2:0] CMD_UP   = 3'd2;
  localparam logic [2:0] CMD_DOWN = 3'd3;
  localparam logic [2:0] CMD_RTC  = 3'd4;
  localparam logic [2:0] CMD_TEMP = 3'd5;

  // menu modes
  localparam logic [1:0] MODE_CLOCK = 2'd0;
  localparam logic [1:0] MODE_TIME  = 2'd1;
  localparam logic [1:0] MODE_ALARM = 2'd2;
  localparam logic [1:0] MODE_LIMIT = 2'd3;

  // set-time fields
  localparam logic [2:0] FLD_HOUR   = 3'd0;
  localparam logic [2:0] FLD_MINUTE = 3'd1;
  localparam logic [2:0] FLD_SECOND = 3'd2;
  localparam logic [2:0] FLD_DATE   = 3'd3;
  localparam logic [2:0] FLD_MONTH  = 3'd4;
  localparam logic [2:0] FLD_YEAR   = 3'd5;
  localparam logic [2:0] FLD_TIME_LAST  = 3'd5;
  localparam logic [2:0] FLD_ALARM_LAST = 3'd1;

  localparam logic [6:0] HOUR_TOP  = 7'd23;
  localparam logic [6:0] MIN_TOP   = 7'd59;
  localparam logic [6:0] DATE_TOP  = 7'd31;
  localparam logic [6:0] MONTH_TOP = 7'd12;
  localparam logic [6:0] YEAR_TOP  = 7'd99;
  localparam logic [6:0] LOW_ZERO  = 7'd0;
  localparam logic [6:0] LOW_ONE   = 7'd1;

  localparam logic signed [11:0] LIMIT_MAX   = 12'sd1250;
  localparam logic signed [11:0] LIMIT_MIN   = -12'sd550;
  localparam logic signed [11:0] LIMIT_STEP  = 12'sd10;
  localparam logic signed [11:0] LIMIT_RESET = 12'sd350;
  localparam logic [4:0]         ALM_HOUR_RESET = 5'd7;
  localparam logic [5:0]         ALM_MIN_RESET  = 6'd30;

  // input word payload, lowest field last
  typedef struct packed {
    logic [2:0]        pad;
    logic signed [11:0] temperature_sample;
    logic [6:0]        new_year;
    logic [3:0]        new_month;
    logic [4:0]        new_date;
    logic [5:0]        new_second;
    logic [5:0]        new_minute;
    logic [4:0]        new_hour;
  } in_word_t;

  // result word, lowest field last
  typedef struct packed {
    logic              pad;
    logic              rtc_write;
    logic              buzzer;
    logic signed [11:0] limit_out;
    logic [5:0]        alarm_minute_out;
    logic [4:0]        alarm_hour_out;
    logic [6:0]        year_two_digit;
    logic [3:0]        month_of_year;
    logic [4:0]        day_of_month;
    logic [5:0]        second;
    logic [5:0]        minute;
    logic [4:0]        hour;
    logic [4:0]        menu_state;
  } out_word_t;

  // handoff from the input stage to the update core
  typedef struct packed {
    logic     valid;
    logic [2:0] command;
    in_word_t data;
  } item_t;

  function automatic logic [6:0] wrap_up(logic [6:0] v, logic [6:0] top, logic [6:0] low);
    logic [7:0] inc;
    inc = {1'b0, v} + 8'd1;
    wrap_up = (inc > {1'b0, top}) ? low : inc[6:0];
  endfunction

  function automatic logic [6:0] wrap_down(logic [6:0] v, logic [6:0] top, logic [6:0] low);
    wrap_down = (v <= low) ? top : v - 7'd1;
  endfunction

endpackage

// ----- hw/rtl/clock_alarm_setting_controller_top.sv -----
// alarm clock set-mode controller, top level
// Each command word passes through an input register, the update logic
// against the menu, clock, alarm and limit registers, and a result
// register, so a word is taken every cycle while the result side keeps up,
// and its result word is presented from the result register.
// While a result waits to be taken, one more word is taken into the input
// register; after that in_tready stays low until the waiting result is taken.
// Every word gives exactly one result word with the state after it.
module clock_alarm_setting_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // command
  // new_hour, new_minute, new_second, new_date, new_month, new_year,
  // temperature_sample, zero pad
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // menu_state, hour, minute, second, day_of_month, month_of_year,
  // year_two_digit, alarm_hour_out, alarm_minute_out, limit_out, buzzer,
  // rtc_write, zero pad
  output logic [63:0] out_tdata
);

  casc_pkg::item_t     item;
  casc_pkg::out_word_t result;
  casc_pkg::out_word_t result_r;
  logic                out_valid_r, out_valid_nxt;
  logic                advance;

  assign advance = item.valid && (!out_valid_r || out_tready);

  casc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .item      (item)
  );

  casc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

  // leaving set-time mode always lands on set-alarm with the first field
  a_rtc_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.rtc_write) |->
      (result_r.menu_state == {casc_pkg::MODE_ALARM, casc_pkg::FLD_HOUR}))
    else $error("rtc_write without move to alarm mode");

  a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((result_r.limit_out <= casc_pkg::LIMIT_MAX) &&
                     (result_r.limit_out >= casc_pkg::LIMIT_MIN)))
    else $error("limit out of range");

  a_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((result_r.menu_state[4:3] == casc_pkg::MODE_CLOCK) ||
                     (result_r.menu_state[4:3] == casc_pkg::MODE_LIMIT))) |->
      (result_r.menu_state[2:0] == casc_pkg::FLD_HOUR))
    else $error("field selected outside set-time and set-alarm modes");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r)
    else $error("result dropped while stalled");

endmodule

// ----- hw/rtl/casc_in_stage.sv -----
// input register stage for command words
module casc_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2:0]           in_tuser,
  input  logic [47:0]          in_tdata,
  input  logic                 advance,
  output casc_pkg::item_t      item
);

  logic               valid_r, valid_nxt;
  logic [2:0]         cmd_r;
  casc_pkg::in_word_t data_r;

  assign in_tready = !valid_r || advance;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser;
      data_r <= casc_pkg::in_word_t'(in_tdata);
    end
  end

  assign item.valid   = valid_r;
  assign item.command = cmd_r;
  assign item.data    = data_r;

endmodule

// ----- hw/rtl/casc_core.sv -----
// menu state registers and the per-word update logic
module casc_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  casc_pkg::item_t       item,
  input  logic                  advance,
  output casc_pkg::out_word_t   result
);

  logic [1:0]         mode_r, mode_nxt;
  logic [2:0]         field_r, field_nxt;
  logic [4:0]         hour_r, hour_nxt;
  logic [5:0]         minute_r, minute_nxt;
  logic [5:0]         second_r, second_nxt;
  logic [4:0]         date_r, date_nxt;
  logic [3:0]         month_r, month_nxt;
  logic [6:0]         year_r, year_nxt;
  logic [4:0]         ahour_r, ahour_nxt;
  logic [5:0]         amin_r, amin_nxt;
  logic signed [11:0] limit_r, limit_nxt;
  logic signed [11:0] temp_r, temp_nxt;
  logic               rtc_write;

  always_comb begin
    logic up;
    logic step;
    logic signed [12:0] lim_up;
    logic signed [12:0] lim_dn;

    mode_nxt   = mode_r;
    field_nxt  = field_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    date_nxt   = date_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    ahour_nxt  = ahour_r;
    amin_nxt   = amin_r;
    limit_nxt  = limit_r;
    temp_nxt   = temp_r;
    rtc_write  = 1'b0;

    up     = (item.command == casc_pkg::CMD_UP);
    step   = (item.command == casc_pkg::CMD_UP) || (item.command == casc_pkg::CMD_DOWN);
    lim_up = 13'(limit_r) + 13'(casc_pkg::LIMIT_STEP);
    lim_dn = 13'(limit_r) - 13'(casc_pkg::LIMIT_STEP);

    case (item.command)
      casc_pkg::CMD_MODE: begin
        rtc_write = (mode_r == casc_pkg::MODE_TIME);
        mode_nxt  = mode_r + 2'd1;
        field_nxt = '0;
      end
      casc_pkg::CMD_SET: begin
        if (mode_r == casc_pkg::MODE_TIME) begin
          field_nxt = (field_r >= casc_pkg::FLD_TIME_LAST) ? 3'd0 : field_r + 3'd1;
        end else if (mode_r == casc_pkg::MODE_ALARM) begin
          field_nxt = (field_r >= casc_pkg::FLD_ALARM_LAST) ? 3'd0 : field_r + 3'd1;
        end
      end
      casc_pkg::CMD_RTC: begin
        if (mode_r != casc_pkg::MODE_TIME) begin
          hour_nxt   = item.data.new_hour;
          minute_nxt = item.data.new_minute;
          second_nxt = item.data.new_second;
          date_nxt   = item.data.new_date;
          month_nxt  = item.data.new_month;
          year_nxt   = item.data.new_year;
        end
      end
      casc_pkg::CMD_TEMP: begin
        temp_nxt = item.data.temperature_sample;
      end
      default: begin
      end
    endcase

    if (step) begin
      if (mode_r == casc_pkg::MODE_TIME) begin
        case (field_r)
          casc_pkg::FLD_HOUR: hour_nxt = up ?
            5'(casc_pkg::wrap_up(7'(hour_r), casc_pkg::HOUR_TOP, casc_pkg::LOW_ZERO)) :
            5'(casc_pkg::wrap_down(7'(hour_r), casc_pkg::HOUR_TOP, casc_pkg::LOW_ZERO));
          casc_pkg::FLD_MINUTE: minute_nxt = up ?
            6'(casc_pkg::wrap_up(7'(minute_r), casc_pkg::MIN_TOP, casc_pkg::LOW_ZERO)) :
            6'(casc_pkg::wrap_down(7'(minute_r), casc_pkg::MIN_TOP, casc_pkg::LOW_ZERO));
          casc_pkg::FLD_SECOND: second_nxt = up ?
            6'(casc_pkg::wrap_up(7'(second_r), casc_pkg::MIN_TOP, casc_pkg::LOW_ZERO)) :
            6'(casc_pkg::wrap_down(7'(second_r), casc_pkg::MIN_TOP, casc_pkg::LOW_ZERO));
          casc_pkg::FLD_DATE: date_nxt = up ?
            5'(casc_pkg::wrap_up(7'(date_r), casc_pkg::DATE_TOP, casc_pkg::LOW_ONE)) :
            5'(casc_pkg::wrap_down(7'(date_r), casc_pkg::DATE_TOP, casc_pkg::LOW_ONE));
          casc_pkg::FLD_MONTH: month_nxt = up ?
            4'(casc_pkg::wrap_up(7'(month_r), casc_pkg::MONTH_TOP, casc_pkg::LOW_ONE)) :
            4'(casc_pkg::wrap_down(7'(month_r), casc_pkg::MONTH_TOP, casc_pkg::LOW_ONE));
          casc_pkg::FLD_YEAR: year_nxt = up ?
            casc_pkg::wrap_up(year_r, casc_pkg::YEAR_TOP, casc_pkg::LOW_ZERO) :
            casc_pkg::wrap_down(year_r, casc_pkg::YEAR_TOP, casc_pkg::LOW_ZERO);
          default: begin
          end
        endcase
      end else if (mode_r == casc_pkg::MODE_ALARM) begin
        if (field_r == casc_pkg::FLD_HOUR) begin
          ahour_nxt = up ?
            5'(casc_pkg::wrap_up(7'(ahour_r), casc_pkg::HOUR_TOP, casc_pkg::LOW_ZERO)) :
            5'(casc_pkg::wrap_down(7'(ahour_r), casc_pkg::HOUR_TOP, casc_pkg::LOW_ZERO));
        end else begin
          amin_nxt = up ?
            6'(casc_pkg::wrap_up(7'(amin_r), casc_pkg::MIN_TOP, casc_pkg::LOW_ZERO)) :
            6'(casc_pkg::wrap_down(7'(amin_r), casc_pkg::MIN_TOP, casc_pkg::LOW_ZERO));
        end
      end else if (mode_r == casc_pkg::MODE_LIMIT) begin
        // saturate at the ends of the limit range
        if (up) begin
          limit_nxt = (lim_up > 13'(casc_pkg::LIMIT_MAX)) ? casc_pkg::LIMIT_MAX : lim_up[11:0];
        end else begin
          limit_nxt = (lim_dn < 13'(casc_pkg::LIMIT_MIN)) ? casc_pkg::LIMIT_MIN : lim_dn[11:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= casc_pkg::MODE_CLOCK;
      field_r  <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      date_r   <= '0;
      month_r  <= '0;
      year_r   <= '0;
      ahour_r  <= casc_pkg::ALM_HOUR_RESET;
      amin_r   <= casc_pkg::ALM_MIN_RESET;
      limit_r  <= casc_pkg::LIMIT_RESET;
      temp_r   <= '0;
    end else if (advance) begin
      mode_r   <= mode_nxt;
      field_r  <= field_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      date_r   <= date_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      ahour_r  <= ahour_nxt;
      amin_r   <= amin_nxt;
      limit_r  <= limit_nxt;
      temp_r   <= temp_nxt;
    end
  end

  // result reflects the state after this word
  assign result.pad              = 1'b0;
  assign result.rtc_write        = rtc_write;
  assign result.buzzer           = ((hour_nxt == ahour_nxt) && (minute_nxt == amin_nxt)) ||
                                   (temp_nxt >= limit_nxt);
  assign result.limit_out        = limit_nxt;
  assign result.alarm_minute_out = amin_nxt;
  assign result.alarm_hour_out   = ahour_nxt;
  assign result.year_two_digit   = year_nxt;
  assign result.month_of_year    = month_nxt;
  assign result.day_of_month     = date_nxt;
  assign result.second           = second_nxt;
  assign result.minute           = minute_nxt;
  assign result.hour             = hour_nxt;
  assign result.menu_state       = {mode_nxt, field_nxt};

endmodule
